// ===== design/sdgc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdgc_pkg
// Shared types and constants for the sum-hash duplicate group counter.
// ----------------------------------------------------------------------------
`default_nettype none

package sdgc_pkg;

    // Result and occupancy field widths
    localparam int HASH_W  = 12;
    localparam int COUNT_W = 13;
    localparam int OCC_W   = 2;

    // Occupancy and group counter limits
    localparam logic [OCC_W-1:0]   OCC_MAX   = 2'd3;
    localparam logic [OCC_W-1:0]   DUP_LEVEL = 2'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

    // Request action codes
    typedef enum logic [1:0] {
        ACT_BYTE  = 2'd0,
        ACT_FINAL = 2'd1,
        ACT_EMPTY = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    // Control states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

endpackage

`default_nettype wire

// ===== design/sdgc_ram.sv =====
// ----------------------------------------------------------------------------
// sdgc_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sdgc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/sum_hash_duplicate_group_counter.sv =====
// ----------------------------------------------------------------------------
// sum_hash_duplicate_group_counter
// Additive record hash with bucket occupancy and duplicate group counting.
// ----------------------------------------------------------------------------
// Usage:
//   A request (action, content_byte) is taken at a rising edge where start is
//   high and busy is low. Byte requests add the byte to the running sum and
//   leave busy low, so a record streams in at one byte per cycle.
//   At a record end (final byte or empty record) the bucket count is read
//   from the occupancy RAM in the accept cycle and written back in the next,
//   during which busy is high. The result appears on record_hash,
//   new_group and group_count for exactly one cycle with done high, from
//   registers loaded in the update state. The receiver cannot stall; results
//   must be taken in the cycle they are shown.
//   A clear request, and reset, sweep the occupancy RAM one entry per cycle:
//   busy stays high until the sweep ends. Sum and group count clear at once.
//   BUCKETS must be a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module sum_hash_duplicate_group_counter
    import sdgc_pkg::*;
#(
    parameter int BUCKETS = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         action,
    input  wire logic [7:0]         content_byte,
    output logic                    done,
    output logic      [HASH_W-1:0]  record_hash,
    output logic                    new_group,
    output logic      [COUNT_W-1:0] group_count
);

    localparam int AW = $clog2(BUCKETS);

    state_t state_reg;
    state_t state_next;

    logic [AW-1:0]      sum_reg;
    logic [AW-1:0]      sum_next;
    logic [AW-1:0]      slot_reg;
    logic [AW-1:0]      slot_next;
    logic [AW-1:0]      clr_addr_reg;
    logic [COUNT_W-1:0] groups_reg;
    logic               done_reg;
    logic               new_group_reg;
    logic [HASH_W-1:0]  hash_reg;

    logic               accept;
    logic               is_end;
    logic [AW-1:0]      byte_ext;
    logic [AW-1:0]      sum_plus;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [OCC_W-1:0]   ram_wdata;
    logic [OCC_W-1:0]   occ_rd;
    logic               occ_bump;
    logic [OCC_W-1:0]   occ_inc;
    logic               fresh;

    // Decode the request
    assign accept   = start && !busy;
    assign is_end   = (action == ACT_FINAL) || (action == ACT_EMPTY);
    assign byte_ext = AW'(content_byte);
    assign sum_plus = sum_reg + byte_ext;

    // Pick the bucket that a record end reads
    always_comb
    begin
        slot_next = sum_reg;
        if (action == ACT_FINAL)
        begin
            slot_next = sum_plus;
        end
    end

    // Occupancy update from the read data
    assign occ_bump = (occ_rd != OCC_MAX);
    assign occ_inc  = occ_rd + OCC_W'(1);
    assign fresh    = occ_bump && (occ_inc == DUP_LEVEL);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (action == ACT_CLEAR))
                begin
                    state_next = ST_CLEAR;
                end
                else if (accept && is_end)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs of the state machine: busy flag and RAM write port
    always_comb
    begin
        busy      = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = slot_reg;
        ram_wdata = occ_inc;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_UPDATE:
            begin
                ram_we = occ_bump;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Running sum of the current record
    always_comb
    begin
        sum_next = sum_reg;
        if (accept)
        begin
            case (action)
                ACT_BYTE:  sum_next = sum_plus;
                ACT_FINAL: sum_next = '0;
                ACT_EMPTY: sum_next = '0;
                ACT_CLEAR: sum_next = '0;
                default:   sum_next = sum_reg;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            sum_reg      <= '0;
            groups_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            done_reg  <= (state_reg == ST_UPDATE);
            // Advance the sweep address; it wraps to zero at the end
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            // Drop the group count on clear, count new groups otherwise
            if (accept && (action == ACT_CLEAR))
            begin
                groups_reg <= '0;
            end
            else if ((state_reg == ST_UPDATE) && fresh && (groups_reg != COUNT_MAX))
            begin
                groups_reg <= groups_reg + COUNT_W'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg <= slot_next;
        end
        if (state_reg == ST_UPDATE)
        begin
            hash_reg      <= HASH_W'(slot_reg);
            new_group_reg <= fresh;
        end
    end

    // Bucket occupancy store
    sdgc_ram #(
        .WIDTH (OCC_W),
        .DEPTH (BUCKETS)
    ) u_occ_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (slot_next),
        .rdata (occ_rd)
    );

    assign done        = done_reg;
    assign record_hash = hash_reg;
    assign new_group   = new_group_reg;
    assign group_count = groups_reg;

endmodule

`default_nettype wire
